>>> src/sha_pkg.sv
`default_nettype none
package sha_pkg;

  typedef logic [31:0] word_t;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam int unsigned ROUNDS = 64;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned LEN_HI_SLOT = 14;

  typedef struct packed {
    logic load;
    logic run;
    logic fold;
  } comp_ctrl_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

>>> src/sha_round.sv
`default_nettype none
// One compression round per cycle over the eight working words, with the
// rolling 16-word schedule; also folds the result into the chaining value.
module sha_round (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sha_pkg::comp_ctrl_t ctrl,
  input  wire logic [5:0]         round,
  input  wire sha_pkg::word_t     block_word,
  input  wire logic               iv_load,
  input  wire logic [2:0]         cv_sel,
  output sha_pkg::word_t          cv_word
);

  sha_pkg::word_t cv [8];
  sha_pkg::word_t v [8];
  sha_pkg::word_t win [16];
  sha_pkg::word_t w, s0, s1, t1, t2, x2, x15;

  always_comb begin
    x2  = win[4'(round - 6'd2)];
    x15 = win[4'(round - 6'd15)];
    s1 = sha_pkg::rotr(x2, 17) ^ sha_pkg::rotr(x2, 19) ^ (x2 >> 10);
    s0 = sha_pkg::rotr(x15, 7) ^ sha_pkg::rotr(x15, 18) ^ (x15 >> 3);
    if (round < 6'd16) begin
      w = block_word;
    end else begin
      w = s1 + win[4'(round - 6'd7)] + s0 + win[round[3:0]];
    end
    t1 = v[7] + (sha_pkg::rotr(v[4], 6) ^ sha_pkg::rotr(v[4], 11)
         ^ sha_pkg::rotr(v[4], 25)) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
         + sha_pkg::ROUND_K[round] + w;
    t2 = (sha_pkg::rotr(v[0], 2) ^ sha_pkg::rotr(v[0], 13)
         ^ sha_pkg::rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  assign cv_word = cv[cv_sel];

  always_ff @(posedge clk) begin
    if (rst || iv_load) begin
      for (int i = 0; i < 8; i++) cv[i] <= sha_pkg::IV[i];
    end else if (ctrl.fold) begin
      for (int i = 0; i < 8; i++) cv[i] <= cv[i] + v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < 8; i++) v[i] <= cv[i];
    end else if (ctrl.run) begin
      win[round[3:0]] <= w;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule
`default_nettype wire

>>> src/sha_ctrl.sv
`default_nettype none
// Sequencer: accepts words into the block buffer, generates padding and
// length words, runs compressions and streams the digest.
module sha_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire sha_pkg::word_t      msg_word,
  input  wire logic [2:0]          valid_bytes,
  input  wire logic                last_word,
  output logic                     busy,
  output sha_pkg::comp_ctrl_t      ctrl,
  output logic [5:0]               round,
  output sha_pkg::word_t           block_word,
  output logic                     iv_load,
  output logic [2:0]               cv_sel,
  output logic                     out_valid,
  output logic [2:0]               out_index
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PAD  = 6'b000010,
    S_LOAD = 6'b000100,
    S_RUN  = 6'b001000,
    S_FOLD = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state;
  sha_pkg::word_t buffer [16];
  logic [3:0] fill;
  logic [63:0] bit_length;
  logic finishing, len_done, mark_due;
  logic [2:0] k;
  sha_pkg::word_t mask, padded, pad_word;
  logic accept;

  assign accept = start && state == S_IDLE;
  assign busy = state != S_IDLE;
  assign k = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;

  always_comb begin
    case (k)
      3'd0:    mask = 32'h0;
      3'd1:    mask = 32'hff000000;
      3'd2:    mask = 32'hffff0000;
      3'd3:    mask = 32'hffffff00;
      default: mask = 32'hffffffff;
    endcase
    padded = (msg_word & mask) | (32'h80 << (5'd24 - {k[1:0], 3'b000}));
    // len_done is set once the high length word is in; the low word follows
    if (mark_due) begin
      pad_word = 32'h80000000;
    end else if (!len_done && fill == 4'(sha_pkg::LEN_HI_SLOT)) begin
      pad_word = bit_length[63:32];
    end else if (len_done && fill == 4'(sha_pkg::LEN_HI_SLOT + 1)) begin
      pad_word = bit_length[31:0];
    end else begin
      pad_word = '0;
    end
  end

  assign ctrl.load = state == S_LOAD;
  assign ctrl.run  = state == S_RUN;
  assign ctrl.fold = state == S_FOLD;
  assign block_word = buffer[round[3:0]];
  assign cv_sel = out_index;
  assign out_valid = state == S_OUT;
  assign iv_load = state == S_OUT && out_index == 3'd7;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      bit_length <= '0;
      round <= '0;
      out_index <= '0;
      finishing <= 1'b0;
      len_done <= 1'b0;
      mark_due <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!last_word) begin
              buffer[fill] <= msg_word;
              fill <= fill + 4'd1;
              bit_length <= bit_length + 64'd32;
              if (fill == 4'd15) state <= S_LOAD;
            end else if (k == 3'd4) begin
              // full last word: 0x80 goes in a word of its own
              buffer[fill] <= msg_word;
              bit_length <= bit_length + 64'd32;
              finishing <= 1'b1;
              if (fill == 4'd15) begin
                // block closes here, 0x80 opens the next one
                fill <= '0;
                mark_due <= 1'b1;
                state <= S_LOAD;
              end else begin
                buffer[fill + 4'd1] <= 32'h80000000;
                fill <= fill + 4'd2;
                state <= (fill == 4'd14) ? S_LOAD : S_PAD;
              end
            end else begin
              buffer[fill] <= padded;
              fill <= fill + 4'd1;
              bit_length <= bit_length + 64'({k, 3'b000});
              finishing <= 1'b1;
              state <= (fill == 4'd15) ? S_LOAD : S_PAD;
            end
          end
        end
        S_PAD: begin
          buffer[fill] <= pad_word;
          fill <= fill + 4'd1;
          if (mark_due) begin
            mark_due <= 1'b0;
          end else if (!len_done && fill == 4'(sha_pkg::LEN_HI_SLOT)) begin
            len_done <= 1'b1;
          end
          if (fill == 4'd15) state <= S_LOAD;
        end
        S_LOAD: begin
          round <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          round <= round + 6'd1;
          if (round == 6'(sha_pkg::ROUNDS - 1)) state <= S_FOLD;
        end
        S_FOLD: begin
          fill <= '0;
          if (!finishing) begin
            state <= S_IDLE;
          end else if (len_done) begin
            out_index <= '0;
            state <= S_OUT;
          end else begin
            state <= S_PAD;
          end
        end
        S_OUT: begin
          out_index <= out_index + 3'd1;
          if (out_index == 3'd7) begin
            state <= S_IDLE;
            finishing <= 1'b0;
            len_done <= 1'b0;
            bit_length <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/sha256_message_hash.sv
`default_nettype none
// channel  | ports                                       | handshake
// input    | msg_word, valid_bytes, last_word            | start && !busy
// result   | digest_word, word_index, last_of_digest     | digest_valid
// A word that does not close a block is just stored; a closing block then
// runs load, 64 rounds on the shared round unit, and fold. Padding writes
// its pad words in S_PAD and may add a second block; digest is eight words.
// Reset returns the chaining value to the initial values.
// The receiver cannot stall; each digest beat shows for one cycle.
module sha256_message_hash (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] msg_word,
  input  wire logic [2:0]  valid_bytes,
  input  wire logic        last_word,
  output logic             digest_valid,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_of_digest
);

  sha_pkg::comp_ctrl_t ctrl;
  logic [5:0] round;
  sha_pkg::word_t block_word, cv_word;
  logic iv_load;
  logic [2:0] cv_sel;

  sha_ctrl u_ctrl (
    .clk, .rst, .start, .msg_word, .valid_bytes, .last_word, .busy,
    .ctrl, .round, .block_word, .iv_load, .cv_sel,
    .out_valid(digest_valid), .out_index(word_index)
  );

  sha_round u_round (
    .clk, .rst, .ctrl, .round, .block_word, .iv_load, .cv_sel, .cv_word
  );

  assign digest_word = cv_word;
  assign last_of_digest = digest_valid && word_index == 3'd7;

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> busy) else $error("digest beat while idle");
  a_last: assert property (@(posedge clk) disable iff (rst)
    last_of_digest |=> !digest_valid) else $error("digest overrun");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && word_index != 3'd7) |=> digest_valid)
    else $error("digest gap");

endmodule
`default_nettype wire
